// ----- hw/rtl/rolling_hash_prefix_store_assert.svh -----
// Assertion macros for the rolling hash prefix store.
`ifndef ROLLING_HASH_PREFIX_STORE_ASSERT_SVH
`define ROLLING_HASH_PREFIX_STORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RHPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RHPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RHPS_ASSERT_IMP(lbl, ante, cons, msg)
`define RHPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rhps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rhps_pkg;

  localparam int MAX_LEN = 4096;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int HASH_W  = 61;
  localparam int BYTE_W  = 8;

  localparam logic [HASH_W-1:0] HASH_MOD   = {HASH_W{1'b1}};
  localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(1000003);
  localparam logic [LEN_W-1:0]  MAX_LEN_V  = LEN_W'(MAX_LEN);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REPLY,
    S_LOAD,
    S_MUL_LL,
    S_MUL_LH,
    S_MUL_HL,
    S_MUL_HH,
    S_MUL_ACC,
    S_MUL_MID,
    S_MUL_FOLD,
    S_HSUM,
    S_WRITE,
    S_QEND,
    S_QSUB
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LEN,
    RD_QRY,
    RD_END
  } rd_sel_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PH_BASE,
    OP_PW_BASE,
    OP_PH_PW
  } op_src_t;

  typedef enum logic [1:0] {
    MS_LL,
    MS_LH,
    MS_HL,
    MS_HH
  } mul_sel_t;

  typedef enum logic [2:0] {
    AC_NONE,
    AC_SET_LOW,
    AC_MID_SET,
    AC_MID_ADD,
    AC_ADD_HH,
    AC_ADD_MID,
    AC_FOLD
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_PH,
    RES_H,
    RES_SUB
  } res_src_t;

  typedef struct packed {
    logic     in_load;
    logic     len_clr;
    logic     len_inc;
    rd_sel_t  rd_sel;
    op_src_t  op_ld;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     h_ld;
    logic     wr_en;
    logic     emit;
    res_src_t res_src;
    status_t  res_status;
  } ctl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    pos_bad;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rolling_hash_prefix_store.sv -----
// Channel    Ports                                          Handshake
// config     cfg_wr_en, cfg_wr_data                         write when cfg_wr_en
// request    in_action, in_char_byte, in_start_pos,         taken when start && !busy
//            in_sub_len, in_to_end
// result     out_hash_value, out_cur_length, out_status     out_strobe, one cycle
//
// busy covers decode alone for a clear or a rejected query, the reply for a full
// append or action 3, and the multiply steps for a query or an append; the strobe
// follows in the next cycle, when a new request may already be taken. One shared
// 31x31 multiplier builds each modular product in seven steps; an append needs two.
// Synchronous active-low reset; entry zero of both stores is decoded from the
// address, so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
`include "rolling_hash_prefix_store_assert.svh"

module rolling_hash_prefix_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rhps_pkg::HASH_W-1:0] cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [rhps_pkg::BYTE_W-1:0] in_char_byte,
  input  logic [rhps_pkg::LEN_W-1:0]  in_start_pos,
  input  logic [rhps_pkg::LEN_W-1:0]  in_sub_len,
  input  logic                        in_to_end,
  output logic                        out_strobe,
  output logic [rhps_pkg::HASH_W-1:0] out_hash_value,
  output logic [rhps_pkg::LEN_W-1:0]  out_cur_length,
  output logic [1:0]                  out_status
);
  import rhps_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rhps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rhps_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_action),
    .in_char_byte   (in_char_byte),
    .in_start_pos   (in_start_pos),
    .in_sub_len     (in_sub_len),
    .in_to_end      (in_to_end),
    .cmd            (cmd),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_hash_value (out_hash_value),
    .out_cur_length (out_cur_length),
    .out_status     (out_status)
  );

  `RHPS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request taken but block not busy")
  `RHPS_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than a cycle")
  `RHPS_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result strobe while busy")
  `RHPS_ASSERT_IMP(a_range_zero, out_strobe && (out_status == 2'(ST_RANGE)), out_hash_value == '0, "range error with nonzero hash")

endmodule

`default_nettype wire

// ----- hw/rtl/rhps_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rhps_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rhps_pkg::HASH_W-1:0] cfg_wr_data,
  input  logic [1:0]                  in_action,
  input  logic [rhps_pkg::BYTE_W-1:0] in_char_byte,
  input  logic [rhps_pkg::LEN_W-1:0]  in_start_pos,
  input  logic [rhps_pkg::LEN_W-1:0]  in_sub_len,
  input  logic                        in_to_end,
  input  rhps_pkg::ctl_cmd_t          cmd,
  output rhps_pkg::dp_stat_t          stat,
  output logic                        out_strobe,
  output logic [rhps_pkg::HASH_W-1:0] out_hash_value,
  output logic [rhps_pkg::LEN_W-1:0]  out_cur_length,
  output logic [1:0]                  out_status
);
  import rhps_pkg::*;

  function automatic logic [HASH_W-1:0] fold61(input logic [63:0] x);
    logic [HASH_W:0] r;
    r = {{(HASH_W - 2){1'b0}}, x[63:61]} + {1'b0, x[HASH_W-1:0]};
    if (r >= {1'b0, HASH_MOD}) r = r - {1'b0, HASH_MOD};
    return r[HASH_W-1:0];
  endfunction

  logic [HASH_W-1:0] ph_mem [0:MAX_LEN];
  logic [HASH_W-1:0] pw_mem [0:MAX_LEN];

  logic [HASH_W-1:0] base_r;
  logic [LEN_W-1:0]  len_r;
  action_t           act_r;
  logic [BYTE_W-1:0] byte_r;
  logic [LEN_W-1:0]  pos_r;
  logic [LEN_W-1:0]  sub_len_r;
  logic              to_end_r;
  logic [LEN_W-1:0]  plen_r;

  logic [HASH_W-1:0] ph_rd_r;
  logic [HASH_W-1:0] pw_rd_r;
  logic              ph_zero_r;
  logic              pw_zero_r;

  logic [HASH_W-1:0] opa_r;
  logic [HASH_W-1:0] opb_r;
  logic [61:0]       pp_r;
  logic [62:0]       mid_r;
  logic [63:0]       acc_r;
  logic [HASH_W-1:0] mul_res_r;
  logic [HASH_W-1:0] h_r;

  logic              out_strobe_r;
  logic [HASH_W-1:0] out_hash_r;
  status_t           out_status_r;

  logic [LEN_W:0]    span_c;
  logic [LEN_W-1:0]  plen_c;
  logic [LEN_W-1:0]  ph_addr;
  logic [LEN_W-1:0]  pw_addr;
  logic [LEN_W-1:0]  wr_addr;
  logic [HASH_W-1:0] ph_val;
  logic [HASH_W-1:0] pw_val;
  logic [30:0]       mul_a;
  logic [30:0]       mul_b;
  logic [61:0]       pp_c;
  logic [HASH_W:0]   hsum_c;
  logic [HASH_W-1:0] hnew_c;
  logic [HASH_W:0]   diff_c;
  logic [HASH_W-1:0] res_c;

  assign stat.act     = act_r;
  assign stat.full    = (len_r == MAX_LEN_V);
  assign stat.pos_bad = (pos_r > len_r);

  // clip the substring at the end of the string
  always_comb begin
    span_c = {1'b0, pos_r} + {1'b0, sub_len_r};
    if (to_end_r || span_c >= {1'b0, len_r}) begin
      plen_c = len_r - pos_r;
    end else begin
      plen_c = sub_len_r;
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LEN: begin
        ph_addr = len_r;
        pw_addr = len_r;
      end
      RD_QRY: begin
        ph_addr = pos_r;
        pw_addr = plen_c;
      end
      RD_END: begin
        ph_addr = pos_r + plen_r;
        pw_addr = plen_r;
      end
      default: begin
        ph_addr = len_r;
        pw_addr = len_r;
      end
    endcase
  end

  assign wr_addr = len_r + LEN_W'(1);
  assign ph_val  = ph_zero_r ? '0 : ph_rd_r;
  assign pw_val  = pw_zero_r ? HASH_W'(1) : pw_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_sel != RD_NONE) begin
      ph_rd_r   <= ph_mem[ph_addr];
      ph_zero_r <= (ph_addr == '0);
    end
    if (cmd.wr_en) begin
      ph_mem[wr_addr] <= h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_sel != RD_NONE) begin
      pw_rd_r   <= pw_mem[pw_addr];
      pw_zero_r <= (pw_addr == '0);
    end
    if (cmd.wr_en) begin
      pw_mem[wr_addr] <= mul_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= BASE_RESET;
      len_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (cmd.len_clr) begin
        len_r <= '0;
      end else if (cmd.len_inc) begin
        len_r <= wr_addr;
      end
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      act_r     <= action_t'(in_action);
      byte_r    <= in_char_byte;
      pos_r     <= in_start_pos;
      sub_len_r <= in_sub_len;
      to_end_r  <= in_to_end;
    end
    if (cmd.rd_sel == RD_QRY) begin
      plen_r <= plen_c;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op_ld)
      OP_PH_BASE: begin
        opa_r <= ph_val;
        opb_r <= base_r;
      end
      OP_PW_BASE: begin
        opa_r <= pw_val;
        opb_r <= base_r;
      end
      OP_PH_PW: begin
        opa_r <= ph_val;
        opb_r <= pw_val;
      end
      default: begin
        opa_r <= opa_r;
        opb_r <= opb_r;
      end
    endcase
  end

  // one 31x31 partial product per cycle
  always_comb begin
    unique case (cmd.mul_sel)
      MS_LL: begin
        mul_a = opa_r[30:0];
        mul_b = opb_r[30:0];
      end
      MS_LH: begin
        mul_a = opa_r[30:0];
        mul_b = {1'b0, opb_r[60:31]};
      end
      MS_HL: begin
        mul_a = {1'b0, opa_r[60:31]};
        mul_b = opb_r[30:0];
      end
      default: begin
        mul_a = {1'b0, opa_r[60:31]};
        mul_b = {1'b0, opb_r[60:31]};
      end
    endcase
    pp_c = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    pp_r <= pp_c;
    unique case (cmd.acc_op)
      AC_SET_LOW: acc_r     <= {2'b00, pp_r};
      AC_MID_SET: mid_r     <= {1'b0, pp_r};
      AC_MID_ADD: mid_r     <= mid_r + {1'b0, pp_r};
      AC_ADD_HH:  acc_r     <= acc_r + {1'b0, pp_r, 1'b0};
      AC_ADD_MID: acc_r     <= acc_r + {31'b0, mid_r[62:30]} + {3'b000, mid_r[29:0], 31'b0};
      AC_FOLD:    mul_res_r <= fold61(acc_r);
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  always_comb begin
    hsum_c = {1'b0, mul_res_r} + {{(HASH_W + 1 - BYTE_W){1'b0}}, byte_r};
    if (hsum_c >= {1'b0, HASH_MOD}) begin
      hnew_c = HASH_W'(hsum_c - {1'b0, HASH_MOD});
    end else begin
      hnew_c = hsum_c[HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.h_ld) begin
      h_r <= hnew_c;
    end
  end

  always_comb begin
    if (mul_res_r <= ph_val) begin
      diff_c = {1'b0, ph_val} - {1'b0, mul_res_r};
    end else begin
      diff_c = {1'b0, ph_val} + {1'b0, HASH_MOD} - {1'b0, mul_res_r};
    end
  end

  always_comb begin
    unique case (cmd.res_src)
      RES_ZERO: res_c = '0;
      RES_PH:   res_c = ph_val;
      RES_H:    res_c = h_r;
      RES_SUB:  res_c = diff_c[HASH_W-1:0];
      default:  res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hash_r   <= res_c;
      out_status_r <= cmd.res_status;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_hash_value = out_hash_r;
  assign out_cur_length = len_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rhps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rhps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rhps_pkg::dp_stat_t stat,
  output logic               busy,
  output rhps_pkg::ctl_cmd_t cmd
);
  import rhps_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   pass_r;
  logic   pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_CLEAR: begin
            cmd.len_clr    = 1'b1;
            cmd.emit       = 1'b1;
            cmd.res_src    = RES_ZERO;
            cmd.res_status = ST_OK;
            state_nxt      = S_IDLE;
          end
          ACT_APPEND: begin
            cmd.rd_sel = RD_LEN;
            state_nxt  = stat.full ? S_REPLY : S_LOAD;
          end
          ACT_QUERY: begin
            if (stat.pos_bad) begin
              cmd.emit       = 1'b1;
              cmd.res_src    = RES_ZERO;
              cmd.res_status = ST_RANGE;
              state_nxt      = S_IDLE;
            end else begin
              cmd.rd_sel = RD_QRY;
              state_nxt  = S_LOAD;
            end
          end
          ACT_NOP: begin
            cmd.rd_sel = RD_LEN;
            state_nxt  = S_REPLY;
          end
        endcase
      end
      S_REPLY: begin
        cmd.emit       = 1'b1;
        cmd.res_src    = RES_PH;
        cmd.res_status = (stat.act == ACT_APPEND) ? ST_FULL : ST_OK;
        state_nxt      = S_IDLE;
      end
      S_LOAD: begin
        cmd.op_ld = (stat.act == ACT_QUERY) ? OP_PH_PW : OP_PH_BASE;
        pass_nxt  = 1'b0;
        state_nxt = S_MUL_LL;
      end
      S_MUL_LL: begin
        cmd.mul_sel = MS_LL;
        state_nxt   = S_MUL_LH;
      end
      S_MUL_LH: begin
        cmd.mul_sel = MS_LH;
        cmd.acc_op  = AC_SET_LOW;
        state_nxt   = S_MUL_HL;
      end
      S_MUL_HL: begin
        cmd.mul_sel = MS_HL;
        cmd.acc_op  = AC_MID_SET;
        state_nxt   = S_MUL_HH;
      end
      S_MUL_HH: begin
        cmd.mul_sel = MS_HH;
        cmd.acc_op  = AC_MID_ADD;
        state_nxt   = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        cmd.acc_op = AC_ADD_HH;
        state_nxt  = S_MUL_MID;
      end
      S_MUL_MID: begin
        cmd.acc_op = AC_ADD_MID;
        state_nxt  = S_MUL_FOLD;
      end
      S_MUL_FOLD: begin
        cmd.acc_op = AC_FOLD;
        priority if (stat.act == ACT_QUERY) begin
          state_nxt = S_QEND;
        end else if (!pass_r) begin
          state_nxt = S_HSUM;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_HSUM: begin
        cmd.h_ld  = 1'b1;
        cmd.op_ld = OP_PW_BASE;
        pass_nxt  = 1'b1;
        state_nxt = S_MUL_LL;
      end
      S_WRITE: begin
        cmd.wr_en      = 1'b1;
        cmd.len_inc    = 1'b1;
        cmd.emit       = 1'b1;
        cmd.res_src    = RES_H;
        cmd.res_status = ST_OK;
        state_nxt      = S_IDLE;
      end
      S_QEND: begin
        cmd.rd_sel = RD_END;
        state_nxt  = S_QSUB;
      end
      S_QSUB: begin
        cmd.emit       = 1'b1;
        cmd.res_src    = RES_SUB;
        cmd.res_status = ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire
